// ----- rtl/core/rrc_pkg.sv -----
package rrc_pkg;

   // Field widths of one box and one set of corners.
   localparam int COORD_W   = 16;
   localparam int SIZE_W    = 15;
   localparam int HALF_W    = SIZE_W - 1;
   localparam int ANGLE_W   = 13;

   // Trig values carry TRIG_FRAC fraction bits; a magnitude reaches exactly 1.0.
   localparam int TRIG_FRAC = 15;
   localparam int TRIG_W    = TRIG_FRAC + 1;
   localparam int SC_W      = TRIG_FRAC + 2;

   // Datapath widths behind the multipliers.
   localparam int PROD_W    = HALF_W + 1 + SC_W;
   localparam int ROT_W     = PROD_W - TRIG_FRAC;
   localparam int CTR_W     = COORD_W + 1;
   localparam int SUM_W     = CTR_W + 1;

   // Angle folding: a full turn, one eighth of it, and how many octant
   // boundaries the raw angle field can cross.
   localparam int ANGLE_STEPS   = 5760;
   localparam int OCTANT_STEPS  = ANGLE_STEPS / 8;
   localparam int OCT_THRESH    = ((1 << ANGLE_W) - 1) / OCTANT_STEPS;
   localparam int OCT_W         = $clog2(OCT_THRESH + 1);
   localparam int IDX_W         = $clog2(OCTANT_STEPS + 1);

   // The octant table is split into banks of constant logic.
   localparam int BANK_AW    = 8;
   localparam int BANK_DEPTH = 1 << BANK_AW;
   localparam int BANK_COUNT = (OCTANT_STEPS + BANK_DEPTH) / BANK_DEPTH;
   localparam int BANK_SEL_W = IDX_W - BANK_AW;

   localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
   localparam logic [63:0] Q30_ONE        = 64'd1 << 30;
   localparam logic [63:0] ANGLE_STEPS_64 = 64'(ANGLE_STEPS);

   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quad_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [2*TRIG_W-1:0]       trig_pair_type;

   typedef struct packed {
      coord_type          box_x;
      coord_type          box_y;
      logic [SIZE_W-1:0]  box_w;
      logic [SIZE_W-1:0]  box_h;
      logic [ANGLE_W-1:0] angle;
   } req_data_type;

   typedef struct packed {
      coord_type ul_x;
      coord_type ul_y;
      coord_type ur_x;
      coord_type ur_y;
      coord_type ll_x;
      coord_type ll_y;
      coord_type lr_x;
      coord_type lr_y;
   } rsp_data_type;

   typedef struct packed {
      coord_type          box_x;
      coord_type          box_y;
      logic [HALF_W-1:0]  half_w;
      logic [HALF_W-1:0]  half_h;
      logic [IDX_W-1:0]   idx;
      logic               mirror;
      quad_type           quad;
   } front_type;

   typedef struct packed {
      logic signed [CTR_W-1:0] ctr_x;
      logic signed [CTR_W-1:0] ctr_y;
      logic [HALF_W-1:0]       half_w;
      logic [HALF_W-1:0]       half_h;
      logic signed [SC_W-1:0]  sin_v;
      logic signed [SC_W-1:0]  cos_v;
   } trig_type;

   function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic logic [TRIG_W-1:0] q30_to_trig(input logic [63:0] v);
      logic [63:0] r;
      r = (v + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
      return r[TRIG_W-1:0];
   endfunction

   // Sine (upper half) and cosine (lower half) of octant step idx, from a
   // seven-term Q30 series with every term rounded to nearest.
   function automatic trig_pair_type trig_pair(input int idx);
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] ts;
      logic [63:0] tc;
      logic [63:0] ss;
      logic [63:0] cs;
      t  = (64'(idx) * 64'd4 * HALF_PI_Q30 + ANGLE_STEPS_64 / 64'd2) / ANGLE_STEPS_64;
      t2 = q30_mul(t, t);
      ts = t;
      tc = Q30_ONE;
      ss = t;
      cs = Q30_ONE;
      ts = (q30_mul(ts, t2) + 64'd3) / 64'd6;
      tc = (q30_mul(tc, t2) + 64'd1) / 64'd2;
      ss = ss - ts;
      cs = cs - tc;
      ts = (q30_mul(ts, t2) + 64'd10) / 64'd20;
      tc = (q30_mul(tc, t2) + 64'd6) / 64'd12;
      ss = ss + ts;
      cs = cs + tc;
      ts = (q30_mul(ts, t2) + 64'd21) / 64'd42;
      tc = (q30_mul(tc, t2) + 64'd15) / 64'd30;
      ss = ss - ts;
      cs = cs - tc;
      ts = (q30_mul(ts, t2) + 64'd36) / 64'd72;
      tc = (q30_mul(tc, t2) + 64'd28) / 64'd56;
      ss = ss + ts;
      cs = cs + tc;
      ts = (q30_mul(ts, t2) + 64'd55) / 64'd110;
      tc = (q30_mul(tc, t2) + 64'd45) / 64'd90;
      ss = ss - ts;
      cs = cs - tc;
      ts = (q30_mul(ts, t2) + 64'd78) / 64'd156;
      tc = (q30_mul(tc, t2) + 64'd66) / 64'd132;
      ss = ss + ts;
      cs = cs + tc;
      return {q30_to_trig(ss), q30_to_trig(cs)};
   endfunction

endpackage

// ----- rtl/core/rrc_stream_if.sv -----
interface rrc_stream_if #(
   parameter type data_type = logic
);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/rrc_front.sv -----
module rrc_front import rrc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_data_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output front_type    out_data
);

   logic [OCT_W-1:0]   oct;
   logic [ANGLE_W:0]   base;
   logic [ANGLE_W:0]   diff;
   front_type          data_in;
   front_type          data_ff;
   logic               valid_ff;

   // Count the octant boundaries below the angle. Odd boundaries sit one step
   // higher so that the exact middle of a quadrant stays unmirrored.
   always_comb begin
      oct = '0;
      for (int k = 1; k <= OCT_THRESH; k++) begin
         if ({1'b0, in_data.angle} >= (ANGLE_W + 1)'(OCTANT_STEPS * k + (k & 1))) begin
            oct = oct + OCT_W'(1);
         end
      end
      base = (ANGLE_W + 1)'(OCTANT_STEPS) * (ANGLE_W + 1)'(oct + OCT_W'(oct[0]));
      diff = oct[0] ? base - {1'b0, in_data.angle} : {1'b0, in_data.angle} - base;

      data_in.box_x  = in_data.box_x;
      data_in.box_y  = in_data.box_y;
      data_in.half_w = in_data.box_w[SIZE_W-1:1];
      data_in.half_h = in_data.box_h[SIZE_W-1:1];
      data_in.idx    = diff[IDX_W-1:0];
      data_in.mirror = oct[0];
      data_in.quad   = quad_type'(oct[2:1]);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- rtl/core/rrc_trig_rom.sv -----
module rrc_trig_rom import rrc_pkg::*; #(
   parameter int BASE = 0
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [BANK_AW-1:0] addr,
   output trig_pair_type      rd_data
);

   trig_pair_type rom [BANK_DEPTH];
   trig_pair_type rd_data_ff;

   for (genvar gi = 0; gi < BANK_DEPTH; gi++) begin : g_entry
      assign rom[gi] = trig_pair(BASE + gi);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rd_data_ff <= rom[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rrc_trig.sv -----
module rrc_trig import rrc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  front_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output trig_type  out_data
);

   trig_pair_type           bank_rd [BANK_COUNT];
   trig_pair_type           pair;
   logic [BANK_SEL_W-1:0]   sel;
   logic [TRIG_W-1:0]       s_mag;
   logic [TRIG_W-1:0]       c_mag;
   logic signed [SC_W-1:0]  s0;
   logic signed [SC_W-1:0]  c0;
   logic                    load2;
   logic                    ready2;
   logic                    ready3;
   logic                    valid2_ff;
   front_type               front2_ff;
   logic                    valid3_ff;
   trig_type                data3_in;
   trig_type                data3_ff;

   assign ready3   = !valid3_ff || out_ready;
   assign ready2   = !valid2_ff || ready3;
   assign in_ready = ready2;
   assign load2    = in_valid && ready2;

   for (genvar gb = 0; gb < BANK_COUNT; gb++) begin : g_bank
      rrc_trig_rom #(
         .BASE (gb * BANK_DEPTH)
      ) u_rom (
         .clock   (clock),
         .enable  (load2),
         .addr    (in_data.idx[BANK_AW-1:0]),
         .rd_data (bank_rd[gb])
      );
   end

   always_comb begin
      sel  = front2_ff.idx[IDX_W-1:BANK_AW];
      pair = '0;
      for (int b = 0; b < BANK_COUNT; b++) begin
         if (sel == BANK_SEL_W'(b)) begin
            pair = bank_rd[b];
         end
      end
      // Past the middle of the quadrant the table was read at the mirrored step.
      s_mag = front2_ff.mirror ? pair[TRIG_W-1:0] : pair[2*TRIG_W-1:TRIG_W];
      c_mag = front2_ff.mirror ? pair[2*TRIG_W-1:TRIG_W] : pair[TRIG_W-1:0];
      s0    = $signed({1'b0, s_mag});
      c0    = $signed({1'b0, c_mag});

      unique case (front2_ff.quad)
         QUAD_0: begin
            data3_in.sin_v = s0;
            data3_in.cos_v = c0;
         end
         QUAD_90: begin
            data3_in.sin_v = c0;
            data3_in.cos_v = -s0;
         end
         QUAD_180: begin
            data3_in.sin_v = -s0;
            data3_in.cos_v = -c0;
         end
         QUAD_270: begin
            data3_in.sin_v = -c0;
            data3_in.cos_v = s0;
         end
         default: begin
            data3_in.sin_v = s0;
            data3_in.cos_v = c0;
         end
      endcase

      data3_in.ctr_x  = CTR_W'(front2_ff.box_x) + $signed({1'b0, 2'b00, front2_ff.half_w});
      data3_in.ctr_y  = CTR_W'(front2_ff.box_y) + $signed({1'b0, 2'b00, front2_ff.half_h});
      data3_in.half_w = front2_ff.half_w;
      data3_in.half_h = front2_ff.half_h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (ready2) begin
            valid2_ff <= in_valid;
         end
         if (ready3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         front2_ff <= in_data;
      end
      if (valid2_ff && ready3) begin
         data3_ff <= data3_in;
      end
   end

   assign out_valid = valid3_ff;
   assign out_data  = data3_ff;

endmodule

// ----- rtl/core/rrc_rotate.sv -----
module rrc_rotate import rrc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  trig_type     in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_data_type out_data
);

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ROT_W-1:0]  off_type;

   typedef struct packed {
      logic signed [CTR_W-1:0] ctr_x;
      logic signed [CTR_W-1:0] ctr_y;
      prod_type                w_cos;
      prod_type                h_sin;
      prod_type                w_sin;
      prod_type                h_cos;
   } prod_stage_type;

   typedef struct packed {
      logic signed [CTR_W-1:0] ctr_x;
      logic signed [CTR_W-1:0] ctr_y;
      off_type                 ul_x;
      off_type                 ul_y;
      off_type                 ur_x;
      off_type                 ur_y;
      off_type                 ll_x;
      off_type                 ll_y;
      off_type                 lr_x;
      off_type                 lr_y;
   } off_stage_type;

   // Round to nearest with ties toward plus infinity.
   function automatic off_type round_off(input prod_type v);
      prod_type b;
      b = v + prod_type'(1 << (TRIG_FRAC - 1));
      return off_type'(b >>> TRIG_FRAC);
   endfunction

   function automatic coord_type corner(input logic signed [CTR_W-1:0] c, input off_type r);
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(c) + SUM_W'(r);
      if (s > SUM_W'(coord_type'({1'b0, {(COORD_W - 1){1'b1}}}))) begin
         return {1'b0, {(COORD_W - 1){1'b1}}};
      end else if (s < SUM_W'(coord_type'({1'b1, {(COORD_W - 1){1'b0}}}))) begin
         return {1'b1, {(COORD_W - 1){1'b0}}};
      end
      return s[COORD_W-1:0];
   endfunction

   logic signed [HALF_W:0] hw_s;
   logic signed [HALF_W:0] hh_s;
   prod_stage_type         data4_in;
   prod_stage_type         data4_ff;
   off_stage_type          data5_in;
   off_stage_type          data5_ff;
   rsp_data_type           data6_in;
   rsp_data_type           data6_ff;
   logic                   valid4_ff;
   logic                   valid5_ff;
   logic                   valid6_ff;
   logic                   ready4;
   logic                   ready5;
   logic                   ready6;

   assign ready6   = !valid6_ff || out_ready;
   assign ready5   = !valid5_ff || ready6;
   assign ready4   = !valid4_ff || ready5;
   assign in_ready = ready4;

   always_comb begin
      hw_s           = $signed({1'b0, in_data.half_w});
      hh_s           = $signed({1'b0, in_data.half_h});
      data4_in.ctr_x = in_data.ctr_x;
      data4_in.ctr_y = in_data.ctr_y;
      data4_in.w_cos = prod_type'(hw_s) * prod_type'(in_data.cos_v);
      data4_in.h_sin = prod_type'(hh_s) * prod_type'(in_data.sin_v);
      data4_in.w_sin = prod_type'(hw_s) * prod_type'(in_data.sin_v);
      data4_in.h_cos = prod_type'(hh_s) * prod_type'(in_data.cos_v);
   end

   // Corner offsets are (+-hw, +-hh); each rotated coordinate is a signed sum
   // of two of the four products.
   always_comb begin
      data5_in.ctr_x = data4_ff.ctr_x;
      data5_in.ctr_y = data4_ff.ctr_y;
      data5_in.ul_x  = round_off(data4_ff.h_sin - data4_ff.w_cos);
      data5_in.ul_y  = round_off(-(data4_ff.w_sin + data4_ff.h_cos));
      data5_in.ur_x  = round_off(data4_ff.w_cos + data4_ff.h_sin);
      data5_in.ur_y  = round_off(data4_ff.w_sin - data4_ff.h_cos);
      data5_in.ll_x  = round_off(-(data4_ff.w_cos + data4_ff.h_sin));
      data5_in.ll_y  = round_off(data4_ff.h_cos - data4_ff.w_sin);
      data5_in.lr_x  = round_off(data4_ff.w_cos - data4_ff.h_sin);
      data5_in.lr_y  = round_off(data4_ff.w_sin + data4_ff.h_cos);
   end

   always_comb begin
      data6_in.ul_x = corner(data5_ff.ctr_x, data5_ff.ul_x);
      data6_in.ul_y = corner(data5_ff.ctr_y, data5_ff.ul_y);
      data6_in.ur_x = corner(data5_ff.ctr_x, data5_ff.ur_x);
      data6_in.ur_y = corner(data5_ff.ctr_y, data5_ff.ur_y);
      data6_in.ll_x = corner(data5_ff.ctr_x, data5_ff.ll_x);
      data6_in.ll_y = corner(data5_ff.ctr_y, data5_ff.ll_y);
      data6_in.lr_x = corner(data5_ff.ctr_x, data5_ff.lr_x);
      data6_in.lr_y = corner(data5_ff.ctr_y, data5_ff.lr_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
      end else begin
         if (ready4) begin
            valid4_ff <= in_valid;
         end
         if (ready5) begin
            valid5_ff <= valid4_ff;
         end
         if (ready6) begin
            valid6_ff <= valid5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready4) begin
         data4_ff <= data4_in;
      end
      if (valid4_ff && ready5) begin
         data5_ff <= data5_in;
      end
      if (valid5_ff && ready6) begin
         data6_ff <= data6_in;
      end
   end

   assign out_valid = valid6_ff;
   assign out_data  = data6_ff;

endmodule

// ----- rtl/core/rotated_rect_corners_top.sv -----
// Rotates an axis-aligned box about its center and returns its four corners.
// A request beat carries the box's top-left corner in signed Q12.4 pixels,
// its size in unsigned Q11.4 pixels and an angle in sixteenths of a degree; a
// response beat carries the upper-left, upper-right, lower-left and lower-right
// corners, each saturated to signed Q12.4. Angles at or above a full turn wrap.
// Odd sizes are halved with the fraction dropped, for the center and the
// offsets alike. The block takes one beat per clock unless the response side
// stalls it and returns results in order; six beats can be in flight at once.
// The six stages are: angle folding, table read, sign fixup, the four
// multipliers, rounding, and recentering with saturation. Each stage holds
// only while the stage after it is full and stalled, so empty slots close up
// and request ready drops only when the pipeline is full and the response side
// is stalled. Sine and cosine come from 721 constant entries for the first
// octant, kept in three banks of 256, so no table load or clearing pass runs
// after reset.
module rotated_rect_corners_top import rrc_pkg::*; (
   input logic          clock,
   input logic          reset,
   rrc_stream_if.sink   req_bus,
   rrc_stream_if.source rsp_bus
);

   // Bounds on |sin| + |cos| for any angle, with margin for rounding.
   localparam int MAG_MIN = 1 << TRIG_FRAC;
   localparam int MAG_MAX = (3 << TRIG_FRAC) / 2;

   logic         front_valid;
   logic         front_ready;
   front_type    front_data;
   logic         trig_valid;
   logic         trig_ready;
   trig_type     trig_data;
   logic         req_ready;
   logic         rsp_valid;
   rsp_data_type rsp_data;

   logic [SC_W-1:0] sin_mag;
   logic [SC_W-1:0] cos_mag;
   logic [SC_W:0]   mag_sum;

   // Fold the angle into an octant step, quadrant and mirror flag.
   rrc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_ready),
      .in_data   (req_bus.data),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // Look up sine and cosine and apply the quadrant's swap and signs.
   rrc_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (trig_valid),
      .out_ready (trig_ready),
      .out_data  (trig_data)
   );

   // Rotate the four corner offsets, round, add the center and saturate.
   rrc_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .in_ready  (trig_ready),
      .in_data   (trig_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;
   assign rsp_bus.data  = rsp_data;

   assign sin_mag = trig_data.sin_v[SC_W-1] ? SC_W'(-trig_data.sin_v) : trig_data.sin_v;
   assign cos_mag = trig_data.cos_v[SC_W-1] ? SC_W'(-trig_data.cos_v) : trig_data.cos_v;
   assign mag_sum = {1'b0, sin_mag} + {1'b0, cos_mag};

   // The folded angle never points past the end of the octant table.
   a_octant_range : assert property (@(posedge clock) disable iff (reset)
      front_valid |-> front_data.idx <= IDX_W'(OCTANT_STEPS))
      else $error("octant step beyond table");

   // After quadrant fixup, sine and cosine still describe a unit vector.
   a_unit_vector : assert property (@(posedge clock) disable iff (reset)
      trig_valid |-> (mag_sum >= (SC_W + 1)'(MAG_MIN)) && (mag_sum <= (SC_W + 1)'(MAG_MAX)))
      else $error("sine and cosine off the unit circle");

   // Requests are only held off while every stage is full and the response stalls.
   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid && !rsp_bus.ready)
      else $error("request stalled with room in the pipeline");

endmodule

// ----- tb/rotated_rect_corners_top_test.sv -----
module rotated_rect_corners_top_test import rrc_pkg::*;;

   // One full turn of the angle field and a quarter turn in Q30 radians. The
   // angle is folded onto the first octant with exact integer symmetries before
   // the series is evaluated, so only a small range of the series is used.
   localparam longint unsigned FULL_TURN        = 64'd5760;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30          = 64'd1 << 30;

   localparam longint COORD_MAX   = 32767;
   localparam longint COORD_MIN   = -32768;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     RANDOM_BOXES = 1800;
   localparam int     DRAIN_CYCLES = 24;

   // A directed row: the box and, where the answer is obvious, the corners
   // typed in by hand. Rows that are not pinned go through the predictor.
   typedef struct packed {
      req_data_type box;
      logic         pinned;
      rsp_data_type corners;
   } probe_row_type;

   localparam int NUM_PROBES = 24;

   // Pinned rows cover empty and one-pixel boxes, the four cardinal angles
   // (where sine and cosine are exactly 0 or 1), odd sizes, a wrapped angle and
   // saturation at the top end. The rest hit the octant fold at 45 degrees, angles
   // next to the fold, the last angle of the turn, the top of the angle field
   // and boxes that push rotated corners past the coordinate range.
   localparam probe_row_type PROBES [NUM_PROBES] = '{
      '{'{0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}},
      '{'{100, -50, 0, 0, 1000}, 1'b1, '{100, -50, 100, -50, 100, -50, 100, -50}},
      '{'{-1, -1, 1, 1, 0}, 1'b1, '{-1, -1, -1, -1, -1, -1, -1, -1}},
      '{'{0, 0, 32, 16, 0}, 1'b1, '{0, 0, 32, 0, 0, 16, 32, 16}},
      '{'{0, 0, 33, 17, 0}, 1'b1, '{0, 0, 32, 0, 0, 16, 32, 16}},
      '{'{0, 0, 32, 16, 5760}, 1'b1, '{0, 0, 32, 0, 0, 16, 32, 16}},
      '{'{0, 0, 32, 16, 1440}, 1'b1, '{24, -8, 24, 24, 8, -8, 8, 24}},
      '{'{0, 0, 32, 16, 2880}, 1'b1, '{32, 16, 0, 16, 32, 0, 0, 0}},
      '{'{0, 0, 32, 16, 4320}, 1'b1, '{8, 24, 8, -8, 24, 24, 24, -8}},
      '{'{32767, 32767, 32767, 32767, 0}, 1'b1,
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}},
      '{'{32767, 32767, 32767, 32767, 2880}, 1'b1,
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}},
      '{'{-32768, -32768, 32767, 32767, 0}, 1'b1,
        '{-32768, -32768, -2, -32768, -32768, -2, -2, -2}},
      '{'{-32768, -32768, 0, 32767, 1440}, 1'b0, '0},
      '{'{-32768, 32767, 32767, 0, 2880}, 1'b0, '0},
      '{'{0, 0, 32767, 32767, 720}, 1'b0, '0},
      '{'{160, -320, 640, 480, 719}, 1'b0, '0},
      '{'{160, -320, 640, 480, 721}, 1'b0, '0},
      '{'{-4000, 4000, 1001, 3, 1}, 1'b0, '0},
      '{'{12345, -6789, 1234, 5678, 5759}, 1'b0, '0},
      '{'{0, 0, 32767, 32767, 8191}, 1'b0, '0},
      '{'{-2000, 1500, 77, 4093, 2159}, 1'b0, '0},
      '{'{500, 500, 2047, 1023, 6000}, 1'b0, '0},
      '{'{32767, -32768, 32767, 32767, 4320}, 1'b0, '0},
      '{'{0, 0, 32767, 32767, 4319}, 1'b0, '0}
   };

   const string CORNER_NAMES [8] = '{"ul_x", "ul_y", "ur_x", "ur_y",
                                     "ll_x", "ll_y", "lr_x", "lr_y"};

   logic clock;
   logic reset;

   rrc_stream_if #(.data_type(req_data_type)) req_bus ();
   rrc_stream_if #(.data_type(rsp_data_type)) rsp_bus ();

   rotated_rect_corners_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Corner sets still owed by the block, oldest first.
   rsp_data_type pending_corners [$];

   int boxes_sent;
   int pinned_sent;
   int corner_sets_seen;
   int mismatch_count;
   int cycle_count;
   int burst_left;
   int stall_mode;
   int stall_left;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Seven-term Taylor series for sine and cosine in Q30, every term rounded to
   // nearest. Each new term is the previous one times t squared over the next
   // two factorial factors.
   function automatic void taylor_q30(input longint unsigned t, output longint sin_q30,
                                      output longint cos_q30);
      longint unsigned t_sq;
      longint unsigned sin_term;
      longint unsigned cos_term;
      longint unsigned sin_div;
      longint unsigned cos_div;
      int k;
      t_sq     = (t * t + (64'd1 << 29)) >> 30;
      sin_term = t;
      cos_term = ONE_Q30;
      sin_q30  = longint'(t);
      cos_q30  = longint'(ONE_Q30);
      for (k = 1; k <= 6; k++) begin
         sin_div  = longint'((2 * k) * (2 * k + 1));
         cos_div  = longint'((2 * k - 1) * (2 * k));
         sin_term = (((sin_term * t_sq + (64'd1 << 29)) >> 30) + sin_div / 2) / sin_div;
         cos_term = (((cos_term * t_sq + (64'd1 << 29)) >> 30) + cos_div / 2) / cos_div;
         if (k % 2 == 1) begin
            sin_q30 = sin_q30 - longint'(sin_term);
            cos_q30 = cos_q30 - longint'(cos_term);
         end else begin
            sin_q30 = sin_q30 + longint'(sin_term);
            cos_q30 = cos_q30 + longint'(cos_term);
         end
      end
   endfunction

   // Q30 down to Q1.15, rounded to nearest; the value is never negative here.
   function automatic longint q30_to_q15(input longint v);
      return (v + (64'sd1 << 14)) >>> 15;
   endfunction

   function automatic void sin_cos_of_angle(input logic [ANGLE_W-1:0] angle,
                                            output longint sin_v, output longint cos_v);
      longint unsigned steps;
      longint unsigned quarters;
      longint unsigned quadrant;
      longint unsigned rest;
      longint unsigned folded;
      longint unsigned theta;
      logic            mirror;
      longint          sin_q30;
      longint          cos_q30;
      longint          sin_oct;
      longint          cos_oct;
      steps    = angle % FULL_TURN;
      quarters = 4 * steps;
      quadrant = quarters / FULL_TURN;
      rest     = quarters - quadrant * FULL_TURN;
      // Past 45 degrees within the quadrant, sine and cosine trade places.
      mirror   = (2 * rest > FULL_TURN);
      folded   = mirror ? FULL_TURN - rest : rest;
      theta    = (folded * QUARTER_TURN_Q30 + FULL_TURN / 2) / FULL_TURN;
      taylor_q30(theta, sin_q30, cos_q30);
      sin_oct  = q30_to_q15(mirror ? cos_q30 : sin_q30);
      cos_oct  = q30_to_q15(mirror ? sin_q30 : cos_q30);
      case (quad_type'(quadrant[1:0]))
         QUAD_0: begin
            sin_v = sin_oct;
            cos_v = cos_oct;
         end
         QUAD_90: begin
            sin_v = cos_oct;
            cos_v = -sin_oct;
         end
         QUAD_180: begin
            sin_v = -sin_oct;
            cos_v = -cos_oct;
         end
         default: begin
            sin_v = -cos_oct;
            cos_v = sin_oct;
         end
      endcase
   endfunction

   // Round a Q.15 product sum to an integer, ties toward plus infinity.
   function automatic longint round_product(input longint v);
      return (v + (64'sd1 << 14)) >>> 15;
   endfunction

   function automatic coord_type clamp_coord(input longint v);
      if (v > COORD_MAX) return coord_type'(COORD_MAX);
      if (v < COORD_MIN) return coord_type'(COORD_MIN);
      return coord_type'(v);
   endfunction

   function automatic rsp_data_type rotate_box(input req_data_type box);
      longint    sin_v;
      longint    cos_v;
      longint    half_w;
      longint    half_h;
      longint    ctr_x;
      longint    ctr_y;
      longint    dx;
      longint    dy;
      coord_type pt [8];
      int        k;
      sin_cos_of_angle(box.angle, sin_v, cos_v);
      half_w = longint'(box.box_w >> 1);
      half_h = longint'(box.box_h >> 1);
      ctr_x  = longint'(box.box_x) + half_w;
      ctr_y  = longint'(box.box_y) + half_h;
      // Corners in the order upper-left, upper-right, lower-left, lower-right.
      for (k = 0; k < 4; k++) begin
         dx = (k % 2 == 1) ? half_w : -half_w;
         dy = (k >= 2) ? half_h : -half_h;
         pt[2 * k]     = clamp_coord(ctr_x + round_product(dx * cos_v - dy * sin_v));
         pt[2 * k + 1] = clamp_coord(ctr_y + round_product(dx * sin_v + dy * cos_v));
      end
      return {pt[0], pt[1], pt[2], pt[3], pt[4], pt[5], pt[6], pt[7]};
   endfunction

   // Present one box and hold it until the block takes it. The sender runs in
   // bursts; at the start of a burst it may drop valid for a random gap. Valid
   // is only lowered when a gap follows, so it never gets two nonblocking
   // assignments in one time step.
   task automatic send_box(input req_data_type box, input logic pinned,
                           input rsp_data_type pinned_corners);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // Now and then a long burst with no idling at all.
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 16);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.data  <= box;
      do @(posedge clock); while (!req_bus.ready);
      // The beat was taken at this edge.
      pending_corners.push_back(pinned ? pinned_corners : rotate_box(box));
      boxes_sent++;
      if (pinned) pinned_sent++;
   endtask

   // Hold the sender off until every corner set owed has come back.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_corners.size() != 0);
      burst_left = 0;
   endtask

   // The receiver stalls on its own schedule: stretches of steady ready,
   // stretches of coin-flip ready, and stretches that are mostly stalled.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(8, 80);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
         default: rsp_bus.ready <= ($urandom_range(0, 11) == 0);
      endcase
   end

   // Every response beat is matched against the oldest corner set owed.
   always @(posedge clock) begin : check_beat
      rsp_data_type want;
      logic [127:0] want_bits;
      logic [127:0] got_bits;
      int           f;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d corner sets still owed",
                  cycle_count, pending_corners.size());
         $display("status: fail");
         $finish;
      end else if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         corner_sets_seen++;
         if (pending_corners.size() == 0) begin
            $error("response beat arrived with no box waiting for it");
            mismatch_count++;
         end else begin
            want      = pending_corners.pop_front();
            want_bits = want;
            got_bits  = rsp_bus.data;
            for (f = 0; f < 8; f++) begin
               if (want_bits[127 - 16 * f -: 16] !== got_bits[127 - 16 * f -: 16]) begin
                  $error("%s: expected %0d, got %0d", CORNER_NAMES[f],
                         $signed(want_bits[127 - 16 * f -: 16]),
                         $signed(got_bits[127 - 16 * f -: 16]));
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      req_data_type box;
      int           n;
      int           kind;
      int           settle;

      boxes_sent       = 0;
      pinned_sent      = 0;
      corner_sets_seen = 0;
      mismatch_count   = 0;
      cycle_count      = 0;
      burst_left       = 0;
      stall_mode       = 0;
      stall_left       = 0;
      clock            = 1'b0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed rows first, then a full drain so the random part starts with
      // an empty pipeline.
      for (n = 0; n < NUM_PROBES; n++) begin
         send_box(PROBES[n].box, PROBES[n].pinned, PROBES[n].corners);
      end
      wait_for_drain();

      for (n = 0; n < RANDOM_BOXES; n++) begin
         kind = $urandom_range(0, 9);
         box  = '0;
         case (kind) inside
            // Ordinary sprites: moderate position and size, any angle in the turn.
            [0:4]: begin
               box.box_x = coord_type'(int'($urandom_range(0, 16383)) - 8192);
               box.box_y = coord_type'(int'($urandom_range(0, 16383)) - 8192);
               box.box_w = SIZE_W'($urandom_range(0, 1023));
               box.box_h = SIZE_W'($urandom_range(0, 1023));
               box.angle = ANGLE_W'($urandom_range(0, 5759));
            end
            // Any bit pattern the fields allow, including wrapped angles.
            [5:6]: begin
               box.box_x = coord_type'($urandom);
               box.box_y = coord_type'($urandom);
               box.box_w = SIZE_W'($urandom);
               box.box_h = SIZE_W'($urandom);
               box.angle = ANGLE_W'($urandom_range(0, 8191));
            end
            // Boxes near either edge of the coordinate range, so rotated
            // corners saturate one way or the other.
            7: begin
               box.box_x = $urandom_range(0, 1) ? coord_type'(32767 - $urandom_range(0, 255))
                                                : coord_type'(-32768 + $urandom_range(0, 255));
               box.box_y = $urandom_range(0, 1) ? coord_type'(32767 - $urandom_range(0, 255))
                                                : coord_type'(-32768 + $urandom_range(0, 255));
               box.box_w = SIZE_W'(32767 - $urandom_range(0, 4095));
               box.box_h = SIZE_W'(32767 - $urandom_range(0, 4095));
               box.angle = ANGLE_W'($urandom_range(0, 5759));
            end
            // Right at, or one step off, a multiple of 45 degrees.
            8: begin
               box.box_x = coord_type'($urandom);
               box.box_y = coord_type'($urandom);
               box.box_w = SIZE_W'($urandom_range(0, 8191));
               box.box_h = SIZE_W'($urandom_range(0, 8191));
               box.angle = ANGLE_W'((720 * $urandom_range(0, 8) + $urandom_range(0, 2) + 5759)
                                    % 5760);
            end
            // Angles past a full turn, which must wrap.
            default: begin
               box.box_x = coord_type'(int'($urandom_range(0, 4095)) - 2048);
               box.box_y = coord_type'(int'($urandom_range(0, 4095)) - 2048);
               box.box_w = SIZE_W'($urandom_range(0, 2047));
               box.box_h = SIZE_W'($urandom_range(0, 2047));
               box.angle = ANGLE_W'($urandom_range(5760, 8191));
            end
         endcase
         send_box(box, 1'b0, '0);
         // One pause in the middle lets the pipeline empty under random traffic.
         if (n == RANDOM_BOXES / 2) wait_for_drain();
      end

      // Let the last results come back, then watch a little longer for any
      // stray beat.
      req_bus.valid <= 1'b0;
      while (pending_corners.size() != 0) @(posedge clock);
      for (settle = 0; settle < DRAIN_CYCLES; settle++) @(posedge clock);

      $display("rotated %0d boxes (%0d with hand-checked corners), %0d corner sets back",
               boxes_sent, pinned_sent, corner_sets_seen);
      $display("random gaps and stalls over %0d cycles, %0d field mismatches",
               cycle_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- rotated_rect_corners_top.f -----
rtl/core/rrc_pkg.sv
rtl/core/rrc_stream_if.sv
rtl/core/rrc_front.sv
rtl/core/rrc_trig_rom.sv
rtl/core/rrc_trig.sv
rtl/core/rrc_rotate.sv
rtl/core/rotated_rect_corners_top.sv
tb/rotated_rect_corners_top_test.sv
